### hw/rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude unit.
// Holds the register index codes and the digit-by-digit square root step.
// No dependencies.
package sem_pkg;

   localparam int PIX_W   = 8;
   localparam int ROW_W   = 16;
   localparam int OCOL_W  = 13;
   localparam int CSR_W   = 16;
   localparam int GRAD_W  = 11;
   localparam int SQ_W    = 20;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // partial root and remainder of the integer square root
   typedef struct packed {
      logic [9:0] rem;
      logic [7:0] root;
   } isq_type;

   // four result bits of the restoring square root, two radicand bits per step
   function automatic isq_type isqrt_step4(isq_type acc, logic [7:0] pairs);
      isq_type    r;
      logic [11:0] cur;
      logic [11:0] trial;
      r = acc;
      for (int i = 3; i >= 0; i--) begin
         cur   = {r.rem, pairs[2*i+1 -: 2]};
         trial = {2'b00, r.root, 2'b01};
         if (cur >= trial) begin
            cur    = cur - trial;
            r.root = {r.root[6:0], 1'b1};
         end else begin
            r.root = {r.root[6:0], 1'b0};
         end
         r.rem = cur[9:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/sem_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sobel_edge_magnitude_unit.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream.
// A pixel reaches rsp_valid through the s1 to s4 stage registers and the output register.
// Throughput: one pixel per cycle; a stalled result holds the whole pipeline,
// set by the single output register and the line store read in the first stage.
// Reset (synchronous): clears position, window and stage valids, sets the size to 8192x4096;
// line stores are not cleared; rows 0 and 1, which emit no result, may read them unwritten.
module sobel_edge_magnitude_unit #(
   parameter int MAX_WIDTH = 8192
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [0:0]                csr_index,
   input  logic [sem_pkg::CSR_W-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [sem_pkg::PIX_W-1:0] req_pixel,
   input  logic                      req_frame_start,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [sem_pkg::PIX_W-1:0] rsp_magnitude,
   output logic [sem_pkg::OCOL_W-1:0] rsp_center_column,
   output logic [sem_pkg::ROW_W-1:0] rsp_center_row,
   output logic                      rsp_frame_last
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam logic [16:0] MAXW = 17'(MAX_WIDTH);
   localparam int RST_W = (8192 > MAX_WIDTH) ? MAX_WIDTH : 8192;
   localparam logic [CW-1:0] RST_WLAST = CW'(RST_W - 1);
   localparam logic [sem_pkg::ROW_W-1:0] RST_HLAST = 16'd4095;

   // ---------------- size registers (stored as last index) ----------------
   logic [CW-1:0]               wlast_ff, wlast_in;
   logic [sem_pkg::ROW_W-1:0]   hlast_ff, hlast_in;
   logic [16:0]                 wclamp;
   logic [sem_pkg::ROW_W-1:0]   hclamp;

   always_comb begin
      wclamp = 17'(csr_wdata[13:0]);
      if (wclamp < 17'd3) begin
         wclamp = 17'd3;
      end else if (wclamp > MAXW) begin
         wclamp = MAXW;
      end
      hclamp = csr_wdata;
      if (hclamp < 16'd3) begin
         hclamp = 16'd3;
      end
      wlast_in = CW'(wclamp - 17'd1);
      hlast_in = hclamp - 16'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff <= RST_WLAST;
         hlast_ff <= RST_HLAST;
      end else if (csr_write) begin
         if (csr_index == sem_pkg::CSR_IMAGE_WIDTH) begin
            wlast_ff <= wlast_in;
         end
         if (csr_index == sem_pkg::CSR_IMAGE_HEIGHT) begin
            hlast_ff <= hlast_in;
         end
      end
   end

   // ---------------- handshake ----------------
   logic adv;
   logic accept;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign accept    = adv && req_valid;
   assign req_stall = !adv;

   // ---------------- stage 0: position and line store read ----------------
   logic [CW-1:0]             col_ff, col_in, c0;
   logic [sem_pkg::ROW_W-1:0] row_ff, row_in, r0;
   logic                      emit0, last0, fwd0;

   logic                      s1_valid_ff;
   logic [sem_pkg::PIX_W-1:0] s1_pix_ff;
   logic [CW-1:0]             s1_col_ff;
   logic [sem_pkg::ROW_W-1:0] s1_row_ff;
   logic                      s1_emit_ff, s1_last_ff;
   logic                      s1_fwd_ff;
   logic [sem_pkg::PIX_W-1:0] s1_fwd_a_ff, s1_fwd_b_ff;

   always_comb begin
      c0 = req_frame_start ? '0 : col_ff;
      r0 = req_frame_start ? '0 : row_ff;
      emit0 = (c0 >= CW'(2)) && (c0 <= wlast_ff) && (r0 >= 16'd2) && (r0 <= hlast_ff);
      last0 = (c0 == wlast_ff) && (r0 == hlast_ff);
      // the item in stage 1 writes this entry at the same edge: forward it
      fwd0  = s1_valid_ff && (c0 == s1_col_ff);
      if (c0 >= wlast_ff) begin
         col_in = '0;
         row_in = (r0 >= hlast_ff) ? '0 : r0 + 16'd1;
      end else begin
         col_in = c0 + CW'(1);
         row_in = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- line stores ----------------
   logic [sem_pkg::PIX_W-1:0] ram_a_rd, ram_b_rd;
   logic [sem_pkg::PIX_W-1:0] top1, mid1;
   logic                      s1_write;

   assign s1_write = adv && s1_valid_ff;

   sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (c0),
      .rd_data (ram_a_rd)
   );

   sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock   (clock),
      .wr_en   (s1_write),
      .wr_addr (s1_col_ff),
      .wr_data (mid1),
      .rd_en   (accept),
      .rd_addr (c0),
      .rd_data (ram_b_rd)
   );

   assign top1 = s1_fwd_ff ? s1_fwd_b_ff : ram_b_rd;
   assign mid1 = s1_fwd_ff ? s1_fwd_a_ff : ram_a_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
      if (accept) begin
         s1_pix_ff   <= req_pixel;
         s1_col_ff   <= c0;
         s1_row_ff   <= r0;
         s1_emit_ff  <= emit0;
         s1_last_ff  <= last0;
         s1_fwd_ff   <= fwd0;
         s1_fwd_a_ff <= s1_pix_ff;
         s1_fwd_b_ff <= mid1;
      end
   end

   // ---------------- stage 1: window and gradients ----------------
   logic [sem_pkg::PIX_W-1:0] win_ff [6];
   logic [9:0] left1, right1, up1, down1;
   logic signed [sem_pkg::GRAD_W-1:0] gx1, gy1;

   always_comb begin
      left1  = 10'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + 10'(win_ff[2]);
      right1 = 10'(top1) + {1'b0, mid1, 1'b0} + 10'(s1_pix_ff);
      up1    = 10'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + 10'(top1);
      down1  = 10'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + 10'(s1_pix_ff);
      gx1    = $signed({1'b0, left1}) - $signed({1'b0, right1});
      gy1    = $signed({1'b0, up1}) - $signed({1'b0, down1});
   end

   logic                      s2_valid_ff;
   logic signed [sem_pkg::GRAD_W-1:0] s2_gx_ff, s2_gy_ff;
   logic [CW-1:0]             s2_col_ff;
   logic [sem_pkg::ROW_W-1:0] s2_row_ff;
   logic                      s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         if (s1_valid_ff) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= top1;
            win_ff[4] <= mid1;
            win_ff[5] <= s1_pix_ff;
         end
      end
      if (adv) begin
         s2_gx_ff   <= gx1;
         s2_gy_ff   <= gy1;
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------- stage 2: squares ----------------
   logic signed [21:0] sqx2, sqy2;
   assign sqx2 = s2_gx_ff * s2_gx_ff;
   assign sqy2 = s2_gy_ff * s2_gy_ff;

   logic                      s3_valid_ff;
   logic [sem_pkg::SQ_W-1:0]  s3_sqx_ff, s3_sqy_ff;
   logic [CW-1:0]             s3_col_ff;
   logic [sem_pkg::ROW_W-1:0] s3_row_ff;
   logic                      s3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s3_sqx_ff  <= sqx2[sem_pkg::SQ_W-1:0];
         s3_sqy_ff  <= sqy2[sem_pkg::SQ_W-1:0];
         s3_col_ff  <= s2_col_ff;
         s3_row_ff  <= s2_row_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // ---------------- stage 3: sum, saturation, upper root bits ----------------
   logic [sem_pkg::SQ_W:0] sum3;
   logic                   sat3;
   sem_pkg::isq_type       hi3;

   always_comb begin
      sum3 = {1'b0, s3_sqx_ff} + {1'b0, s3_sqy_ff};
      sat3 = |sum3[sem_pkg::SQ_W:16];
      hi3  = sem_pkg::isqrt_step4('0, sum3[15:8]);
   end

   logic                      s4_valid_ff;
   sem_pkg::isq_type          s4_acc_ff;
   logic [7:0]                s4_low_ff;
   logic                      s4_sat_ff;
   logic [CW-1:0]             s4_col_ff;
   logic [sem_pkg::ROW_W-1:0] s4_row_ff;
   logic                      s4_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv) begin
         s4_acc_ff  <= hi3;
         s4_low_ff  <= sum3[7:0];
         s4_sat_ff  <= sat3;
         s4_col_ff  <= s3_col_ff;
         s4_row_ff  <= s3_row_ff;
         s4_last_ff <= s3_last_ff;
      end
   end

   // ---------------- stage 4: lower root bits, output register ----------------
   sem_pkg::isq_type          lo4;
   logic [sem_pkg::PIX_W-1:0] mag4;
   logic [CW-1:0]             ccol4;

   always_comb begin
      lo4   = sem_pkg::isqrt_step4(s4_acc_ff, s4_low_ff);
      mag4  = s4_sat_ff ? 8'hFF : lo4.root;
      ccol4 = s4_col_ff - CW'(1);
   end

   logic [sem_pkg::PIX_W-1:0]  rsp_mag_ff;
   logic [sem_pkg::OCOL_W-1:0] rsp_col_ff;
   logic [sem_pkg::ROW_W-1:0]  rsp_row_ff;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s4_valid_ff;
      end
      if (adv && s4_valid_ff) begin
         rsp_mag_ff  <= mag4;
         rsp_col_ff  <= sem_pkg::OCOL_W'(ccol4);
         rsp_row_ff  <= s4_row_ff - 16'd1;
         rsp_last_ff <= s4_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_magnitude     = rsp_mag_ff;
   assign rsp_center_column = rsp_col_ff;
   assign rsp_center_row    = rsp_row_ff;
   assign rsp_frame_last    = rsp_last_ff;

endmodule

### hw/rtl/sem_checker.sv
// Port-level checks for the Sobel edge magnitude unit, bound to the top level.
// Depends on sem_pkg and sobel_edge_magnitude_unit.
module sem_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [sem_pkg::PIX_W-1:0]  rsp_magnitude,
   input logic [sem_pkg::OCOL_W-1:0] rsp_center_column,
   input logic [sem_pkg::ROW_W-1:0]  rsp_center_row,
   input logic                       rsp_frame_last
);

   // input is held back only by a result waiting on a stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output backpressure");

   // a result never names column 0 or row 0 as its center
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_center_column != '0 && rsp_center_row != '0))
      else $error("result for a border pixel");

   // the pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

   // a stalled item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_magnitude)
         && $stable(rsp_center_column) && $stable(rsp_center_row)
         && $stable(rsp_frame_last)))
      else $error("stalled result changed");

endmodule

bind sobel_edge_magnitude_unit sem_checker u_sem_checker (.*);

### tb/sv/sobel_edge_magnitude_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for sobel_edge_magnitude_unit: pixel frames of many sizes
// go in with random gaps and results come out under random output stall.
// Depends on sem_pkg and the unit; checks every result against a predictor kept here.
module sobel_edge_magnitude_unit_test;

   localparam int MAX_W         = 8192;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int REPORT_LIMIT  = 10;

   typedef enum int {
      PIX_UNIFORM,
      PIX_EXTREME,
      PIX_SMOOTH
   } pixel_style_type;

   typedef enum int {
      RX_FREE,
      RX_SPARSE,
      RX_PERIODIC,
      RX_HEAVY
   } stall_mode_type;

   typedef struct packed {
      logic [sem_pkg::PIX_W-1:0] pixel;
      logic                      frame_start;
   } pixel_item_type;

   typedef struct packed {
      logic [sem_pkg::PIX_W-1:0]  magnitude;
      logic [sem_pkg::OCOL_W-1:0] column;
      logic [sem_pkg::ROW_W-1:0]  row;
      logic                       last;
   } edge_result_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write;
   logic [0:0]                 csr_index;
   logic [sem_pkg::CSR_W-1:0]  csr_wdata;
   logic                       req_valid;
   logic                       req_stall;
   logic [sem_pkg::PIX_W-1:0]  req_pixel;
   logic                       req_frame_start;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [sem_pkg::PIX_W-1:0]  rsp_magnitude;
   logic [sem_pkg::OCOL_W-1:0] rsp_center_column;
   logic [sem_pkg::ROW_W-1:0]  rsp_center_row;
   logic                       rsp_frame_last;

   // predictor state
   bit [7:0]    row_above [MAX_W];
   bit [7:0]    row_two_above [MAX_W];
   int          win_cols [6];
   int unsigned next_col = 0;
   int unsigned next_row = 0;
   logic [13:0] width_reg = 14'd8192;
   logic [15:0] height_reg = 16'd4096;

   pixel_item_type  pixel_q [$];
   edge_result_type expected_q [$];

   int gap_left, burst_left;
   int hold_left, hold_seen, mode_left;
   int hold_req_count = 0;
   int unsigned pattern_tick = 0;
   stall_mode_type rx_mode;
   int pixels_sent = 0;
   int results_checked = 0;
   int frame_ends = 0;
   int phases_run = 0;
   int mismatch_count = 0;
   int unsigned cycle_count = 0;

   sobel_edge_magnitude_unit #(
      .MAX_WIDTH(MAX_W)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_center_column (rsp_center_column),
      .rsp_center_row    (rsp_center_row),
      .rsp_frame_last    (rsp_frame_last)
   );

   always #5 clock = ~clock;

   function automatic int unsigned eff_width(logic [13:0] w);
      if (w < 3) return 3;
      if (w > MAX_W) return MAX_W;
      return 32'(w);
   endfunction

   function automatic int unsigned eff_height(logic [15:0] h);
      return (h < 3) ? 3 : h;
   endfunction

   function automatic logic [7:0] floor_root_sat(int unsigned v);
      int unsigned root;
      root = 0;
      if (v >= 65536) return 8'd255;
      for (int unsigned b = 128; b != 0; b = b >> 1) begin
         if ((root + b) * (root + b) <= v) root = root + b;
      end
      return 8'(root);
   endfunction

   function automatic logic [7:0] make_pixel(pixel_style_type style, int base);
      int v;
      case (style)
         PIX_UNIFORM: v = int'($urandom_range(0, 255));
         PIX_EXTREME: v = ($urandom_range(0, 1) == 1) ? 255 : 0;
         default:     v = base + int'($urandom_range(0, 8)) - 4;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // Advance the filter by one accepted pixel and queue the edge result it produces, if any.
   task automatic predict_edge(input logic [7:0] pix, input logic fs);
      int unsigned     w, h, c, r, sum;
      int              top, mid, cur, gx, gy;
      edge_result_type res;
      w = eff_width(width_reg);
      h = eff_height(height_reg);
      if (fs) begin
         next_col = 0;
         next_row = 0;
      end
      c = next_col;
      r = next_row;
      top = int'(row_two_above[c]);
      mid = int'(row_above[c]);
      cur = int'(pix);
      if (c >= 2 && c < w && r >= 2 && r < h) begin
         gx = (win_cols[0] + 2 * win_cols[1] + win_cols[2]) - (top + 2 * mid + cur);
         gy = (win_cols[0] + 2 * win_cols[3] + top) - (win_cols[2] + 2 * win_cols[5] + cur);
         sum = gx * gx + gy * gy;
         res.magnitude = floor_root_sat(sum);
         res.column    = 13'(c - 1);
         res.row       = 16'(r - 1);
         res.last      = (c == w - 1 && r == h - 1);
         expected_q.push_back(res);
      end
      win_cols[0] = win_cols[3];
      win_cols[1] = win_cols[4];
      win_cols[2] = win_cols[5];
      win_cols[3] = top;
      win_cols[4] = mid;
      win_cols[5] = cur;
      row_two_above[c] = 8'(mid);
      row_above[c]     = pix;
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endtask

   task automatic write_csr(input sem_pkg::csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == sem_pkg::CSR_IMAGE_WIDTH) begin
         width_reg = value[13:0];
      end else begin
         height_reg = value;
      end
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Wait until nothing is queued, offered or expected, then let the pipeline empty.
   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_pixel(input logic [7:0] p, input logic fs);
      pixel_q.push_back({p, fs});
   endtask

   task automatic run_phase(input int n_pix, input bit restart, input pixel_style_type style,
                            input bit pause_mid, input bit hold_off);
      int base;
      base = int'($urandom_range(0, 255));
      @(negedge clock);
      if (hold_off) hold_req_count++;
      for (int i = 0; i < n_pix; i++) begin
         // hold the sender until every result so far is back
         if (pause_mid && i == n_pix / 2) wait_drained();
         push_pixel(make_pixel(style, base), restart && i == 0);
      end
      wait_drained();
      phases_run++;
   endtask

   // sender: bursts of items with gaps in between
   always @(posedge clock) begin
      pixel_item_type next_item;
      if (reset) begin
         req_valid       <= 1'b0;
         req_pixel       <= '0;
         req_frame_start <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_edge(req_pixel, req_frame_start);
            pixels_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
               next_item = pixel_q.pop_front();
               req_valid       <= 1'b1;
               req_pixel       <= next_item.pixel;
               req_frame_start <= next_item.frame_start;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 9) == 0) begin
                  // long stretch with no idling
                  burst_left = $urandom_range(100, 400);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern switches mode now and then, plus requested hold-offs
   always @(posedge clock) begin
      logic stall_now;
      stall_now = 1'b0;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_seen = 0;
         mode_left = 0;
         rx_mode = RX_FREE;
      end else begin
         if (hold_seen != hold_req_count) begin
            hold_seen = hold_req_count;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            rx_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         pattern_tick++;
         if (hold_left > 0) begin
            hold_left--;
            stall_now = 1'b1;
         end else begin
            case (rx_mode)
               RX_FREE:     stall_now = 1'b0;
               RX_SPARSE:   stall_now = ($urandom_range(0, 7) == 0);
               RX_PERIODIC: stall_now = (pattern_tick % 3 == 0);
               default:     stall_now = ($urandom_range(0, 1) == 1);
            endcase
         end
         rsp_stall <= stall_now;
      end
   end

   // result checker
   always @(posedge clock) begin
      edge_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (rsp_frame_last) frame_ends++;
         if (expected_q.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT) begin
               $display("%0t: unexpected result mag=%0d col=%0d row=%0d last=%0d", $realtime,
                        rsp_magnitude, rsp_center_column, rsp_center_row, rsp_frame_last);
            end
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_magnitude !== want.magnitude || rsp_center_column !== want.column ||
                rsp_center_row !== want.row || rsp_frame_last !== want.last) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("%0t: mismatch exp mag=%0d col=%0d row=%0d last=%0d", $realtime,
                           want.magnitude, want.column, want.row, want.last);
                  $display("%0t:          got mag=%0d col=%0d row=%0d last=%0d", $realtime,
                           rsp_magnitude, rsp_center_column, rsp_center_row, rsp_frame_last);
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
                  expected_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int          sel, n_pix, random_items, phase_idx;
      int unsigned old_w, frame_px, cap;
      logic [15:0] w_val, h_val;
      bit          restart;
      random_items = 0;
      phase_idx = 0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed 3x3 frames
      write_csr(sem_pkg::CSR_IMAGE_WIDTH, 16'd3);
      write_csr(sem_pkg::CSR_IMAGE_HEIGHT, 16'd3);
      @(negedge clock);
      // bright left column: horizontal gradient saturates
      for (int i = 0; i < 9; i++) push_pixel((i % 3 == 0) ? 8'd255 : 8'd0, i == 0);
      // ramp, reached by wrapping into the next frame without frame_start
      for (int i = 0; i < 9; i++) push_pixel(8'(i), 1'b0);
      // stray pixels, then restart mid-row with a bright top row
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd0, 1'b0);
      for (int i = 0; i < 9; i++) push_pixel((i < 3) ? 8'd255 : 8'd0, i == 0);
      wait_drained();
      phases_run++;

      // sizes below range act as 3x3; upper width bits are dropped
      write_csr(sem_pkg::CSR_IMAGE_WIDTH, 16'hC000);
      write_csr(sem_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      run_phase(27, 1'b1, PIX_EXTREME, 1'b0, 1'b0);

      // widest row and tallest frame, then shrink both mid-frame and carry on
      write_csr(sem_pkg::CSR_IMAGE_WIDTH, 16'd8192);
      write_csr(sem_pkg::CSR_IMAGE_HEIGHT, 16'hFFFF);
      run_phase(100, 1'b1, PIX_UNIFORM, 1'b0, 1'b0);
      write_csr(sem_pkg::CSR_IMAGE_WIDTH, 16'd12);
      write_csr(sem_pkg::CSR_IMAGE_HEIGHT, 16'd5);
      run_phase(200, 1'b0, PIX_SMOOTH, 1'b1, 1'b1);

      while (random_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) w_val = 16'($urandom_range(3, 12));
         else if (sel < 88) w_val = 16'($urandom_range(13, 40));
         else if (sel < 95) w_val = 16'($urandom_range(0, 2));
         else w_val = 16'($urandom_range(41, 100));
         if ($urandom_range(0, 7) == 0) w_val[15:14] = 2'($urandom);
         sel = $urandom_range(0, 99);
         if (sel < 75) h_val = 16'($urandom_range(3, 8));
         else if (sel < 85) h_val = 16'($urandom_range(0, 2));
         else if (sel < 95) h_val = 16'($urandom_range(9, 20));
         else h_val = 16'($urandom_range(20000, 65535));
         old_w = eff_width(width_reg);
         if ($urandom_range(0, 3) != 0) write_csr(sem_pkg::CSR_IMAGE_WIDTH, w_val);
         if ($urandom_range(0, 3) != 0) write_csr(sem_pkg::CSR_IMAGE_HEIGHT, h_val);
         // carry on mid-frame only when the row did not grow
         restart = !(eff_width(width_reg) <= old_w && $urandom_range(0, 2) == 0);
         frame_px = eff_width(width_reg) * eff_height(height_reg);
         cap = (2 * frame_px + 4 < 150) ? 2 * frame_px + 4 : 150;
         n_pix = (phase_idx == 2) ? 150 : $urandom_range(eff_width(width_reg), cap);
         run_phase(n_pix, restart, pixel_style_type'($urandom_range(0, 2)),
                   phase_idx == 0 || $urandom_range(0, 9) == 0, phase_idx == 2);
         random_items += n_pix;
         phase_idx++;
      end

      // start of a frame at the clamped maximum width
      write_csr(sem_pkg::CSR_IMAGE_WIDTH, 16'h3FFF);
      write_csr(sem_pkg::CSR_IMAGE_HEIGHT, 16'd3);
      run_phase(60, 1'b1, PIX_SMOOTH, 1'b0, 1'b1);

      $display("Sent %0d pixels in %0d phases; checked %0d edge results, %0d frame ends.",
               pixels_sent, phases_run, results_checked, frame_ends);
      $display("Widths from 3 up to the 8192-column limit, mid-frame resizing, gaps and hold-offs.");
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
